### hw/rtl/lrf_pkg.sv
// Shared types, constants and tables of the lidar ROI filter and clusterer.
package lrf_pkg;

    localparam int MAX_BEAMS    = 2048;
    localparam int MIN_PTS      = 3;
    localparam int MIN_SIZE_MM  = 60;
    localparam int TRIG_BITS    = 10;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 39797;
    localparam int COUNT_MAX    = 4095;
    localparam int CNT_W        = $clog2(MAX_BEAMS + 1);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int NREGS        = 8;
    localparam int ADDR_W       = $clog2(NREGS) + 2;

    localparam logic [2:0] REG_RNG_LO    = 3'd0;
    localparam logic [2:0] REG_RNG_HI    = 3'd1;
    localparam logic [2:0] REG_ROI_XMIN  = 3'd2;
    localparam logic [2:0] REG_ROI_XMAX  = 3'd3;
    localparam logic [2:0] REG_ROI_YBASE = 3'd4;
    localparam logic [2:0] REG_ROI_YRATE = 3'd5;
    localparam logic [2:0] REG_CLUS_TOL  = 3'd6;
    localparam logic [2:0] REG_EMERG     = 3'd7;

    typedef struct packed {
        logic        [15:0] rng_lo;
        logic        [15:0] rng_hi;
        logic signed [15:0] roi_x_min;
        logic signed [15:0] roi_x_max;
        logic        [14:0] roi_y_base;
        logic        [15:0] roi_y_rate;
        logic        [15:0] cluster_tol;
        logic        [15:0] emergency_dist;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ROT, OP_MULX, OP_MULY, OP_WIDTH, OP_TOL,
        OP_DX2, OP_DY2, OP_GROW, OP_CLOSE, OP_START, OP_SUMMARY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic take;
        logic in_roi;
        logic box_open;
        logic join_ok;
        logic last;
        logic out_free;
    } t_sts;

    function automatic logic signed [31:0] atan_val(input logic [STEP_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            4'd0:    v = 32'sd536870912;
            4'd1:    v = 32'sd316933406;
            4'd2:    v = 32'sd167458907;
            4'd3:    v = 32'sd85004756;
            4'd4:    v = 32'sd42667331;
            4'd5:    v = 32'sd21354465;
            4'd6:    v = 32'sd10679838;
            4'd7:    v = 32'sd5340245;
            4'd8:    v = 32'sd2670163;
            4'd9:    v = 32'sd1335087;
            4'd10:   v = 32'sd667544;
            4'd11:   v = 32'sd333772;
            4'd12:   v = 32'sd166886;
            4'd13:   v = 32'sd83443;
            4'd14:   v = 32'sd41722;
            default: v = 32'sd20861;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/lrf_if.sv
// Beam and result channel interfaces.
interface lrf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic        range_valid;
    logic [15:0] beam_angle;
    logic        last_beam;
    modport source (output valid, range_mm, range_valid, beam_angle, last_beam, input ready);
    modport sink   (input valid, range_mm, range_valid, beam_angle, last_beam, output ready);
endinterface

interface lrf_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] box_x_min;
    logic signed [15:0] box_x_max;
    logic signed [15:0] box_y_min;
    logic signed [15:0] box_y_max;
    logic        [11:0] point_total;
    logic        [15:0] nearest_dist;
    logic               emergency;
    logic               last;
    modport source (output valid, kind, box_x_min, box_x_max, box_y_min, box_y_max,
                    point_total, nearest_dist, emergency, last, input ready);
    modport sink   (input valid, kind, box_x_min, box_x_max, box_y_min, box_y_max,
                    point_total, nearest_dist, emergency, last, output ready);
endinterface

### hw/rtl/lrf_regs.sv
// APB configuration registers.
module lrf_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lrf_pkg::t_cfg              o_cfg
);
    lrf_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[lrf_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rng_lo         <= 16'd150;
            r_cfg.rng_hi         <= 16'd3000;
            r_cfg.roi_x_min      <= 16'sd300;
            r_cfg.roi_x_max      <= 16'sd1000;
            r_cfg.roi_y_base     <= 15'd200;
            r_cfg.roi_y_rate     <= 16'd6554;
            r_cfg.cluster_tol    <= 16'd100;
            r_cfg.emergency_dist <= 16'd200;
        end else if (wr) begin
            case (idx)
                lrf_pkg::REG_RNG_LO:    r_cfg.rng_lo         <= pwdata[15:0];
                lrf_pkg::REG_RNG_HI:    r_cfg.rng_hi         <= pwdata[15:0];
                lrf_pkg::REG_ROI_XMIN:  r_cfg.roi_x_min      <= pwdata[15:0];
                lrf_pkg::REG_ROI_XMAX:  r_cfg.roi_x_max      <= pwdata[15:0];
                lrf_pkg::REG_ROI_YBASE: r_cfg.roi_y_base     <= pwdata[14:0];
                lrf_pkg::REG_ROI_YRATE: r_cfg.roi_y_rate     <= pwdata[15:0];
                lrf_pkg::REG_CLUS_TOL:  r_cfg.cluster_tol    <= pwdata[15:0];
                lrf_pkg::REG_EMERG:     r_cfg.emergency_dist <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            lrf_pkg::REG_RNG_LO:    prdata = {16'd0, r_cfg.rng_lo};
            lrf_pkg::REG_RNG_HI:    prdata = {16'd0, r_cfg.rng_hi};
            lrf_pkg::REG_ROI_XMIN:  prdata = {16'd0, r_cfg.roi_x_min};
            lrf_pkg::REG_ROI_XMAX:  prdata = {16'd0, r_cfg.roi_x_max};
            lrf_pkg::REG_ROI_YBASE: prdata = {17'd0, r_cfg.roi_y_base};
            lrf_pkg::REG_ROI_YRATE: prdata = {16'd0, r_cfg.roi_y_rate};
            lrf_pkg::REG_CLUS_TOL:  prdata = {16'd0, r_cfg.cluster_tol};
            lrf_pkg::REG_EMERG:     prdata = {16'd0, r_cfg.emergency_dist};
            default:                prdata = 32'd0;
        endcase
    end
endmodule

### hw/rtl/lrf_datapath.sv
// Datapath: CORDIC, coordinate products, ROI test, box store and result word.
module lrf_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lrf_pkg::t_cfg i_cfg,
    input  lrf_pkg::t_cmd i_cmd,
    output lrf_pkg::t_sts o_sts,
    lrf_in_if.sink        in_ch,
    lrf_out_if.source     out_ch
);
    localparam logic [15:0] ANG_MASK = 16'hFFFF << (16 - lrf_pkg::TRIG_BITS);

    logic        [15:0]            r_range;
    logic                          r_last;
    logic                          r_take;
    logic        [lrf_pkg::CNT_W-1:0] r_cnt;
    logic                          r_flip;
    logic signed [19:0]            r_cx, r_cy;
    logic signed [31:0]            r_cz;
    logic signed [19:0]            r_px, r_py;
    logic signed [17:0]            r_w;
    logic        [31:0]            r_tol2, r_dx2, r_dy2;
    logic                          r_open;
    logic signed [15:0]            r_xmin, r_xmax, r_ymin, r_ymax;
    logic        [11:0]            r_count;
    logic        [15:0]            r_near;
    logic                          r_emerg;
    logic                          r_ov;
    logic                          r_okind, r_olast, r_oemerg;
    logic signed [15:0]            r_oxmin, r_oxmax, r_oymin, r_oymax;
    logic        [11:0]            r_ocount;
    logic        [15:0]            r_onear;

    logic        [15:0] q0, qf, qsum;
    logic               flip0;
    logic signed [19:0] cos_v, sin_v, mul_c;
    logic signed [36:0] prod;
    logic signed [19:0] prod_r;
    logic signed [32:0] wprod;
    logic signed [15:0] px16, py16, dsel_p, dsel_min, dsel_max;
    logic signed [16:0] d_lo, d_hi;
    logic        [15:0] dabs;
    logic        [31:0] dsq;
    logic signed [20:0] ay, wext;
    logic               in_x, in_y, join_ok, box_ok, emit_box;
    logic signed [16:0] ext_x, ext_y;
    logic        [15:0] cand;
    logic               out_free;

    // angle fold into the right half-plane
    always_comb begin
        q0    = in_ch.beam_angle & ANG_MASK;
        qsum  = q0 + 16'h4000;
        flip0 = qsum[15];
        qf    = flip0 ? (q0 ^ 16'h8000) : q0;
    end

    assign cos_v  = r_flip ? -r_cx : r_cx;
    assign sin_v  = r_flip ? -r_cy : r_cy;
    assign mul_c  = (i_cmd.op == lrf_pkg::OP_MULY) ? sin_v : cos_v;
    assign prod   = $signed({21'd0, r_range}) * 37'(mul_c) + 37'sd32768;
    assign prod_r = prod[35:16];

    assign px16  = r_px[15:0];
    assign py16  = (r_py > 20'sd32767) ? 16'sh7FFF :
                   (r_py < -20'sd32768) ? 16'sh8000 : r_py[15:0];
    assign wprod = 33'(px16) * $signed({17'd0, i_cfg.roi_y_rate});

    // edge distance on one axis, shared by both distance steps
    always_comb begin
        if (i_cmd.op == lrf_pkg::OP_DY2) begin
            dsel_p = py16; dsel_min = r_ymin; dsel_max = r_ymax;
        end else begin
            dsel_p = px16; dsel_min = r_xmin; dsel_max = r_xmax;
        end
        d_lo = 17'(dsel_min) - 17'(dsel_p);
        d_hi = 17'(dsel_p) - 17'(dsel_max);
        if (dsel_p < dsel_min)      dabs = d_lo[15:0];
        else if (dsel_p > dsel_max) dabs = d_hi[15:0];
        else                        dabs = 16'd0;
        dsq = 32'(dabs) * 32'(dabs);
    end

    assign in_x    = (r_px >= 20'(i_cfg.roi_x_min)) && (r_px <= 20'(i_cfg.roi_x_max));
    assign ay      = (r_py < 0) ? -21'(r_py) : 21'(r_py);
    assign wext    = 21'(r_w);
    assign in_y    = ay <= wext;
    assign join_ok = ({1'b0, r_dx2} + {1'b0, r_dy2}) <= {1'b0, r_tol2};

    assign ext_x  = 17'(r_xmax) - 17'(r_xmin);
    assign ext_y  = 17'(r_ymax) - 17'(r_ymin);
    assign box_ok = ((ext_x >= 17'(lrf_pkg::MIN_SIZE_MM)) ||
                     (ext_y >= 17'(lrf_pkg::MIN_SIZE_MM))) &&
                    (r_count >= 12'(lrf_pkg::MIN_PTS));
    assign cand     = r_xmin[15] ? 16'd0 : r_xmin;
    assign emit_box = (i_cmd.op == lrf_pkg::OP_CLOSE) && r_open && box_ok;
    assign out_free = !r_ov || out_ch.ready;

    assign in_ch.ready = 1'b0 | (i_cmd.op == lrf_pkg::OP_LOAD);

    assign o_sts.in_valid = in_ch.valid;
    assign o_sts.take     = r_take;
    assign o_sts.in_roi   = in_x && in_y;
    assign o_sts.box_open = r_open;
    assign o_sts.join_ok  = join_ok;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = out_free;

    assign out_ch.valid        = r_ov;
    assign out_ch.kind         = r_okind;
    assign out_ch.box_x_min    = r_oxmin;
    assign out_ch.box_x_max    = r_oxmax;
    assign out_ch.box_y_min    = r_oymin;
    assign out_ch.box_y_max    = r_oymax;
    assign out_ch.point_total  = r_ocount;
    assign out_ch.nearest_dist = r_onear;
    assign out_ch.emergency    = r_oemerg;
    assign out_ch.last         = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_take  <= 1'b0;
            r_last  <= 1'b0;
            r_open  <= 1'b0;
            r_xmin  <= '0;
            r_xmax  <= '0;
            r_ymin  <= '0;
            r_ymax  <= '0;
            r_count <= '0;
            r_near  <= 16'hFFFF;
            r_emerg <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // load a new word, else drop the old one once taken
            if (emit_box || (i_cmd.op == lrf_pkg::OP_SUMMARY)) r_ov <= 1'b1;
            else if (out_ch.ready)                              r_ov <= 1'b0;
            case (i_cmd.op)
                lrf_pkg::OP_LOAD: begin
                    r_range <= in_ch.range_mm;
                    r_last  <= in_ch.last_beam;
                    r_flip  <= flip0;
                    r_cx    <= 20'sd39797;
                    r_cy    <= '0;
                    r_cz    <= {qf, 16'd0};
                    if (r_cnt < lrf_pkg::CNT_W'(lrf_pkg::MAX_BEAMS)) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_take <= in_ch.range_valid &&
                                  (in_ch.range_mm >= i_cfg.rng_lo) &&
                                  (in_ch.range_mm <= i_cfg.rng_hi);
                    end else begin
                        r_take <= 1'b0;
                    end
                end
                lrf_pkg::OP_ROT: begin
                    if (!r_cz[31]) begin
                        r_cx <= r_cx - (r_cy >>> i_cmd.step);
                        r_cy <= r_cy + (r_cx >>> i_cmd.step);
                        r_cz <= r_cz - lrf_pkg::atan_val(i_cmd.step);
                    end else begin
                        r_cx <= r_cx + (r_cy >>> i_cmd.step);
                        r_cy <= r_cy - (r_cx >>> i_cmd.step);
                        r_cz <= r_cz + lrf_pkg::atan_val(i_cmd.step);
                    end
                end
                lrf_pkg::OP_MULX:  r_px <= prod_r;
                lrf_pkg::OP_MULY:  r_py <= prod_r;
                lrf_pkg::OP_WIDTH: r_w  <= 18'($signed(wprod[32:16])) +
                                           18'(i_cfg.roi_y_base);
                lrf_pkg::OP_TOL:   r_tol2 <= 32'(i_cfg.cluster_tol) * 32'(i_cfg.cluster_tol);
                lrf_pkg::OP_DX2:   r_dx2 <= dsq;
                lrf_pkg::OP_DY2:   r_dy2 <= dsq;
                lrf_pkg::OP_GROW: begin
                    if (px16 < r_xmin) r_xmin <= px16;
                    if (px16 > r_xmax) r_xmax <= px16;
                    if (py16 < r_ymin) r_ymin <= py16;
                    if (py16 > r_ymax) r_ymax <= py16;
                    if (r_count != 12'(lrf_pkg::COUNT_MAX)) r_count <= r_count + 1'b1;
                end
                lrf_pkg::OP_CLOSE: begin
                    r_open <= 1'b0;
                    if (emit_box) begin
                        if (cand < r_near) r_near <= cand;
                        if (17'(r_xmin) < $signed({1'b0, i_cfg.emergency_dist}))
                            r_emerg <= 1'b1;
                        r_okind  <= 1'b0;
                        r_oxmin  <= r_xmin;
                        r_oxmax  <= r_xmax;
                        r_oymin  <= r_ymin;
                        r_oymax  <= r_ymax;
                        r_ocount <= r_count;
                        r_onear  <= '0;
                        r_oemerg <= 1'b0;
                        r_olast  <= 1'b0;
                    end
                end
                lrf_pkg::OP_START: begin
                    r_open  <= 1'b1;
                    r_xmin  <= px16;
                    r_xmax  <= px16;
                    r_ymin  <= py16;
                    r_ymax  <= py16;
                    r_count <= 12'd1;
                end
                lrf_pkg::OP_SUMMARY: begin
                    r_okind  <= 1'b1;
                    r_oxmin  <= '0;
                    r_oxmax  <= '0;
                    r_oymin  <= '0;
                    r_oymax  <= '0;
                    r_ocount <= '0;
                    r_onear  <= r_near;
                    r_oemerg <= r_emerg;
                    r_olast  <= 1'b1;
                    r_near   <= 16'hFFFF;
                    r_emerg  <= 1'b0;
                    r_cnt    <= '0;
                    r_open   <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

### hw/rtl/lrf_ctrl.sv
// Sequencer for one beam word at a time.
module lrf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lrf_pkg::t_sts i_sts,
    output lrf_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ROT, S_MULX, S_MULY, S_WIDTH, S_ROI, S_TOL,
        S_DX2, S_DY2, S_JOIN, S_CLOSE, S_START, S_LAST, S_FIN, S_SUM
    } t_state;

    t_state                     r_state, n_state;
    logic [lrf_pkg::STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd.op   = lrf_pkg::OP_NONE;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: if (i_sts.in_valid) begin
                o_cmd.op = lrf_pkg::OP_LOAD;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                n_step  = '0;
                n_state = i_sts.take ? S_ROT : S_LAST;
            end
            S_ROT: begin
                o_cmd.op = lrf_pkg::OP_ROT;
                n_step   = r_step + 1'b1;
                if (r_step == lrf_pkg::STEP_W'(lrf_pkg::CORDIC_STEPS - 1)) n_state = S_MULX;
            end
            S_MULX:  begin o_cmd.op = lrf_pkg::OP_MULX;  n_state = S_MULY;  end
            S_MULY:  begin o_cmd.op = lrf_pkg::OP_MULY;  n_state = S_WIDTH; end
            S_WIDTH: begin o_cmd.op = lrf_pkg::OP_WIDTH; n_state = S_ROI;   end
            S_ROI: begin
                if (!i_sts.in_roi)        n_state = S_LAST;
                else if (i_sts.box_open)  n_state = S_TOL;
                else                      n_state = S_START;
            end
            S_TOL: begin o_cmd.op = lrf_pkg::OP_TOL; n_state = S_DX2; end
            S_DX2: begin o_cmd.op = lrf_pkg::OP_DX2; n_state = S_DY2; end
            S_DY2: begin o_cmd.op = lrf_pkg::OP_DY2; n_state = S_JOIN; end
            S_JOIN: begin
                if (i_sts.join_ok) begin
                    o_cmd.op = lrf_pkg::OP_GROW;
                    n_state  = S_LAST;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            // hold until the result register can take a box word
            S_CLOSE: if (i_sts.out_free) begin
                o_cmd.op = lrf_pkg::OP_CLOSE;
                n_state  = S_START;
            end
            S_START: begin o_cmd.op = lrf_pkg::OP_START; n_state = S_LAST; end
            S_LAST:  n_state = i_sts.last ? S_FIN : S_IDLE;
            S_FIN: if (i_sts.out_free) begin
                o_cmd.op = lrf_pkg::OP_CLOSE;
                n_state  = S_SUM;
            end
            S_SUM: if (i_sts.out_free) begin
                o_cmd.op = lrf_pkg::OP_SUMMARY;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule

### hw/rtl/lidar_roi_filter_cluster.sv
// Lidar ROI filter with sequential bounding-box clustering, top level.
// Beams are taken one word at a time. A beam that is dropped (invalid, out of
// range window or past the beam limit) skips the CORDIC; a beam that becomes a
// point runs the 16-step CORDIC that shares one shift-add unit, plus the
// product, width and distance steps: it may fall outside the region, open a
// box, join the open box, or close it and open a new one. The final beam of a
// scan adds the last box close and the summary, so up to 2 result words. The
// close and summary steps wait while a result word is still held for the sink.
// Results leave through a one-word output register.
module lidar_roi_filter_cluster (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    lrf_in_if.sink                     i_in,
    lrf_out_if.source                  o_out
);
    lrf_pkg::t_cfg cfg;
    lrf_pkg::t_cmd cmd;
    lrf_pkg::t_sts sts;

    lrf_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    lrf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_sts(sts), .o_cmd(cmd)
    );

    lrf_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_cmd(cmd), .o_sts(sts),
        .in_ch(i_in), .out_ch(o_out)
    );
endmodule

### tb/lidar_roi_filter_cluster_test.sv
// Self-checking testbench of the lidar ROI filter and box clusterer.
`timescale 1ns / 1ps

module lidar_roi_filter_cluster_test;
    import lrf_pkg::*;

    typedef struct {
        bit [15:0] rng;
        bit        ok;
        bit [15:0] ang;
        bit        lst;
        bit        typed;
        bit [15:0] near;
    } beam_t;

    typedef struct packed {
        bit                 kind;
        logic signed [15:0] xmn;
        logic signed [15:0] xmx;
        logic signed [15:0] ymn;
        logic signed [15:0] ymx;
        bit          [11:0] tot;
        bit          [15:0] near;
        bit                 em;
        bit                 lst;
    } box_word_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    lrf_in_if  beam_if ();
    lrf_out_if box_if ();

    lidar_roi_filter_cluster u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (beam_if),
        .o_out   (box_if)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the filter settings and the clustering state.
    int unsigned cf_rmin, cf_rmax, cf_base, cf_rate, cf_tol, cf_emd;
    int          cf_xlo, cf_xhi;
    bit          box_open;
    int          ox_min, ox_max, oy_min, oy_max;
    int unsigned ocount, scan_near, beams_seen;
    bit          scan_em;

    box_word_t   pending_boxes[$];
    beam_t       beams[$];
    int          errors = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold = 1'b0;

    initial begin
        beam_if.valid       = 1'b0;
        beam_if.range_mm    = '0;
        beam_if.range_valid = 1'b0;
        beam_if.beam_angle  = '0;
        beam_if.last_beam   = 1'b0;
        box_if.ready        = 1'b0;
    end

    function automatic void sine_cosine(input bit [15:0] ang, output longint c,
                                        output longint s);
        bit [15:0] q;
        bit [15:0] qs;
        bit        flip;
        longint    x, y, z, nx;
        q    = ang & ~16'((1 << (16 - TRIG_BITS)) - 1);
        qs   = q + 16'h4000;
        flip = qs[15];
        if (flip) q ^= 16'h8000;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'($signed(q)) * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_val(4'(i)));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_val(4'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void expect_word(input box_word_t w);
        pending_boxes.insert(pending_boxes.size(), w);
    endfunction

    function automatic void close_open_box();
        box_word_t w;
        int unsigned cand;
        if (!box_open) return;
        box_open = 1'b0;
        if ((ox_max - ox_min >= MIN_SIZE_MM || oy_max - oy_min >= MIN_SIZE_MM) &&
            ocount >= MIN_PTS) begin
            cand = ox_min < 0 ? 0 : ox_min;
            if (cand < scan_near) scan_near = cand;
            if (ox_min < int'(cf_emd)) scan_em = 1'b1;
            w      = '0;
            w.xmn  = 16'(ox_min);
            w.xmx  = 16'(ox_max);
            w.ymn  = 16'(oy_min);
            w.ymx  = 16'(oy_max);
            w.tot  = 12'(ocount);
            expect_word(w);
        end
    endfunction

    function automatic void grow_boxes(input int px, input int py);
        longint dx, dy, tol;
        if (box_open) begin
            dx  = 0;
            dy  = 0;
            tol = cf_tol;
            if (px < ox_min) dx = longint'(ox_min) - px;
            if (px > ox_max) dx = longint'(px) - ox_max;
            if (py < oy_min) dy = longint'(oy_min) - py;
            if (py > oy_max) dy = longint'(py) - oy_max;
            if (dx * dx + dy * dy <= tol * tol) begin
                if (px < ox_min) ox_min = px;
                if (px > ox_max) ox_max = px;
                if (py < oy_min) oy_min = py;
                if (py > oy_max) oy_max = py;
                if (ocount < COUNT_MAX) ocount++;
                return;
            end
            close_open_box();
        end
        box_open = 1'b1;
        ox_min = px;
        ox_max = px;
        oy_min = py;
        oy_max = py;
        ocount = 1;
    endfunction

    // Work out the words that one accepted beam gives.
    function automatic void predict_boxes(input beam_t b);
        longint    c, s, x, y, w, ay;
        box_word_t sw;
        if (beams_seen < MAX_BEAMS) begin
            beams_seen++;
            if (b.ok && b.rng >= cf_rmin && b.rng <= cf_rmax) begin
                sine_cosine(b.ang, c, s);
                x = (longint'(b.rng) * c + 32768) >>> 16;
                y = (longint'(b.rng) * s + 32768) >>> 16;
                if (x >= cf_xlo && x <= cf_xhi) begin
                    w  = longint'(cf_base) + ((x * longint'(cf_rate)) >>> 16);
                    ay = y < 0 ? -y : y;
                    if (ay <= w) begin
                        if (y > 32767) y = 32767;
                        if (y < -32768) y = -32768;
                        grow_boxes(int'(x), int'(y));
                    end
                end
            end
        end
        if (b.lst) begin
            close_open_box();
            sw      = '0;
            sw.kind = 1'b1;
            sw.near = b.typed ? b.near : 16'(scan_near);
            sw.em   = b.typed ? 1'b0 : scan_em;
            sw.lst  = 1'b1;
            expect_word(sw);
            scan_near  = 65535;
            scan_em    = 1'b0;
            beams_seen = 0;
            box_open   = 1'b0;
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RNG_LO:    cf_rmin = value & 16'hFFFF;
            REG_RNG_HI:    cf_rmax = value & 16'hFFFF;
            REG_ROI_XMIN:  cf_xlo  = int'($signed(16'(value)));
            REG_ROI_XMAX:  cf_xhi  = int'($signed(16'(value)));
            REG_ROI_YBASE: cf_base = value & 16'h7FFF;
            REG_ROI_YRATE: cf_rate = value & 16'hFFFF;
            REG_CLUS_TOL:  cf_tol  = value & 16'hFFFF;
            default:       cf_emd  = value & 16'hFFFF;
        endcase
    endtask

    task automatic set_filter(input int rmin, rmax, xlo, xhi, base, rate, tol, emd);
        write_reg(REG_RNG_LO, rmin);
        write_reg(REG_RNG_HI, rmax);
        write_reg(REG_ROI_XMIN, xlo);
        write_reg(REG_ROI_XMAX, xhi);
        write_reg(REG_ROI_YBASE, base);
        write_reg(REG_ROI_YRATE, rate);
        write_reg(REG_CLUS_TOL, tol);
        write_reg(REG_EMERG, emd);
    endtask

    // Offer queued beams one word at a time; predict on acceptance.
    task automatic send_beams();
        beam_t b;
        while (beams.size() > 0) begin
            b = beams.pop_front();
            if (idle_on && $urandom_range(99) < 24) begin
                beam_if.valid <= 1'b0;
                @(posedge i_clk);
                while ($urandom_range(99) < 24) @(posedge i_clk);
            end
            beam_if.valid       <= 1'b1;
            beam_if.range_mm    <= b.rng;
            beam_if.range_valid <= b.ok;
            beam_if.beam_angle  <= b.ang;
            beam_if.last_beam   <= b.lst;
            do @(posedge i_clk); while (!beam_if.ready);
            predict_boxes(b);
        end
        beam_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_boxes.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void add_beam(input int rng, input bit ok, input int ang,
                                     input bit lst);
        beam_t b;
        b       = '{default: '0};
        b.rng   = 16'(rng);
        b.ok    = ok;
        b.ang   = 16'(ang);
        b.lst   = lst;
        beams.insert(beams.size(), b);
    endfunction

    // Scans of clustered beams inside the range window, with some noise.
    function automatic void random_scans(input int n_items);
        int unsigned lo, hi, rng;
        int          ang, left;
        lo = cf_rmin < cf_rmax ? cf_rmin : cf_rmax;
        hi = cf_rmin < cf_rmax ? cf_rmax : cf_rmin;
        while (n_items > 0) begin
            left = $urandom_range(4, 30);
            if (left > n_items) left = n_items;
            case ($urandom_range(2))
                0:       ang = $urandom_range(4095) - 2048;
                1:       ang = $urandom_range(9000, 12000);
                default: ang = $urandom_range(65535);
            endcase
            rng = $urandom_range(lo, hi);
            for (int i = 0; i < left; i++) begin
                ang += 64 * $urandom_range(0, 2);
                if ($urandom_range(99) < 10) rng = $urandom_range(lo, hi);
                else begin
                    rng = rng + $urandom_range(60) - 30;
                    if (rng < lo || rng > hi) rng = $urandom_range(lo, hi);
                end
                if ($urandom_range(99) < 6)
                    add_beam($urandom_range(65535), $urandom_range(1),
                             $urandom_range(65535), i == left - 1);
                else
                    add_beam(rng, $urandom_range(99) >= 8, ang, i == left - 1);
            end
            n_items -= left;
        end
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        box_if.ready <= !hold && (!idle_on || $urandom_range(99) >= 24);
    end

    initial begin
        wait (hold_req);
        hold = 1'b1;
        repeat (600) @(posedge i_clk);
        hold = 1'b0;
    end

    always @(posedge i_clk) begin
        box_word_t want;
        box_word_t got;
        if (i_rst_n && box_if.valid && box_if.ready) begin
            got = {box_if.kind, box_if.box_x_min, box_if.box_x_max, box_if.box_y_min,
                   box_if.box_y_max, box_if.point_total, box_if.nearest_dist,
                   box_if.emergency, box_if.last};
            if (pending_boxes.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %p", $time, got);
            end else begin
                want = pending_boxes.pop_front();
                if (want.kind != got.kind || want.xmn != got.xmn || want.xmx != got.xmx ||
                    want.ymn != got.ymn || want.ymx != got.ymx || want.tot != got.tot ||
                    want.near != got.near || want.em != got.em || want.lst != got.lst) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    // Stop if nothing moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((beam_if.valid && beam_if.ready) || (box_if.valid && box_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= 4000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    beam_t stim_rows[] = '{
        '{0,     1, 16'h0000, 1, 1, 16'hFFFF},
        '{400,   1, 16'h0000, 0, 0, 0},
        '{450,   1, 16'h0040, 0, 0, 0},
        '{500,   1, 16'h0000, 0, 0, 0},
        '{0,     0, 16'h0000, 1, 0, 0},
        '{65535, 1, 16'hFFFF, 0, 0, 0},
        '{150,   1, 16'h0000, 0, 0, 0},
        '{3000,  1, 16'h0000, 0, 0, 0},
        '{3001,  1, 16'h0000, 0, 0, 0},
        '{350,   0, 16'h0000, 0, 0, 0},
        '{600,   1, 16'h8000, 0, 0, 0},
        '{700,   1, 16'h4000, 0, 0, 0},
        '{700,   1, 16'hC000, 0, 0, 0},
        '{600,   1, 16'h0040, 0, 0, 0},
        '{900,   1, 16'hFFC0, 1, 0, 0},
        '{65535, 0, 16'hFFFF, 1, 1, 16'hFFFF}
    };

    initial begin
        cf_rmin = 150;  cf_rmax = 3000;
        cf_xlo  = 300;  cf_xhi  = 1000;
        cf_base = 200;  cf_rate = 6554;
        cf_tol  = 100;  cf_emd  = 200;
        box_open = 1'b0;
        ox_min = 0; ox_max = 0; oy_min = 0; oy_max = 0;
        ocount = 0; scan_near = 65535; scan_em = 1'b0; beams_seen = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) beams.insert(beams.size(), stim_rows[i]);
        send_beams();
        random_scans(60);
        send_beams();
        wait_drained();

        idle_on = 1'b0;
        set_filter(0, 65535, -32768, 32767, 32767, 65535, 65535, 65535);
        random_scans(70);
        send_beams();
        wait_drained();
        idle_on = 1'b1;

        set_filter(3000, 150, 300, 1000, 200, 6554, 100, 200);
        random_scans(30);
        send_beams();
        wait_drained();

        set_filter(150, 3000, 1000, 300, 200, 6554, 100, 200);
        random_scans(30);
        send_beams();
        wait_drained();

        set_filter(0, 65535, -500, 2000, 0, 65535, 0, 0);
        random_scans(64);
        send_beams();
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            set_filter($urandom_range(1000), $urandom_range(1000, 8000),
                       $urandom_range(2500) - 2000, $urandom_range(500, 8000),
                       $urandom_range(2000), $urandom_range(65535),
                       $urandom_range(20, 400), $urandom_range(2000));
            random_scans(50);
            if (p == 0) hold_req = 1'b1;
            send_beams();
            wait_drained();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
